[hw/rtl/hdtb_pkg.sv]
// Shared types, constants and the hex digit decoder for the hex dump parser.
// No dependencies.
package hdtb_pkg;

   localparam int ADDR_W      = 48;
   localparam int COL_W       = 9;
   localparam int MAX_COLUMNS = 256;
   localparam int CSR_DATA_W  = 48;
   localparam int CSR_IDX_W   = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_COLUMNS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POSTSCRIPT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE       = 2'd2;

   localparam logic [COL_W-1:0] COLUMNS_RESET = 9'd16;

   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_LOW_A  = 8'h61;
   localparam logic [7:0] CH_LOW_F  = 8'h66;
   localparam logic [7:0] CH_UP_A   = 8'h41;
   localparam logic [7:0] CH_UP_F   = 8'h46;

   // A digit slot: vld low means "no digit".
   typedef struct packed {
      logic       vld;
      logic [3:0] val;
   } digit_type;

   typedef struct packed {
      logic [COL_W-1:0]  cols;      // already clamped to 1..MAX_COLUMNS
      logic              ps;
      logic [ADDR_W-1:0] base;
   } cfg_type;

   function automatic digit_type hex_value(input logic [7:0] ch);
      digit_type d;
      d.vld = 1'b0;
      d.val = 4'd0;
      if (ch >= CH_ZERO && ch <= CH_NINE) begin
         d.vld = 1'b1;
         d.val = 4'(ch - CH_ZERO);
      end else if (ch >= CH_LOW_A && ch <= CH_LOW_F) begin
         d.vld = 1'b1;
         d.val = 4'(ch - CH_LOW_A + 8'd10);
      end else if (ch >= CH_UP_A && ch <= CH_UP_F) begin
         d.vld = 1'b1;
         d.val = 4'(ch - CH_UP_A + 8'd10);
      end
      return d;
   endfunction

endpackage

[hw/rtl/hdtb_csr.sv]
// Configuration registers of the hex dump parser.
// Depends on hdtb_pkg.
module hdtb_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [hdtb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [hdtb_pkg::CSR_DATA_W-1:0]   csr_data,
   output hdtb_pkg::cfg_type                 cfg
);

   logic [hdtb_pkg::COL_W-1:0]  cols_ff;
   logic                        ps_ff;
   logic [hdtb_pkg::ADDR_W-1:0] base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= hdtb_pkg::COLUMNS_RESET;
         ps_ff   <= 1'b0;
         base_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            hdtb_pkg::CSR_COLUMNS:    cols_ff <= csr_data[hdtb_pkg::COL_W-1:0];
            hdtb_pkg::CSR_POSTSCRIPT: ps_ff   <= csr_data[0];
            hdtb_pkg::CSR_BASE:       base_ff <= csr_data[hdtb_pkg::ADDR_W-1:0];
            default: ;
         endcase
      end
   end

   // zero acts as one column, anything above the maximum saturates
   always_comb begin
      cfg.ps   = ps_ff;
      cfg.base = base_ff;
      if (cols_ff == '0)
         cfg.cols = hdtb_pkg::COL_W'(1);
      else if (cols_ff > hdtb_pkg::COL_W'(hdtb_pkg::MAX_COLUMNS))
         cfg.cols = hdtb_pkg::COL_W'(hdtb_pkg::MAX_COLUMNS);
      else
         cfg.cols = cols_ff;
   end

endmodule

[hw/rtl/hdtb_parse.sv]
// Parser state and the per-character step: digit pairing, line offsets,
// garbage and line skipping. Depends on hdtb_pkg.
module hdtb_parse (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        fire,
   input  logic [7:0]                  ch,
   input  hdtb_pkg::cfg_type           cfg,
   output logic                        emit,
   output logic [hdtb_pkg::ADDR_W-1:0] addr,
   output logic [7:0]                  data
);

   logic                        ig_ff, ig_in;
   hdtb_pkg::digit_type         last_ff, last_in;
   hdtb_pkg::digit_type         prior_ff, prior_in;
   logic                        addr_ph_ff, addr_ph_in;
   logic [hdtb_pkg::COL_W-1:0]  bol_ff, bol_in;
   logic                        skip_ff, skip_in;
   logic [hdtb_pkg::ADDR_W-1:0] ro_ff, ro_in;

   hdtb_pkg::digit_type         n;
   logic                        is_lf;
   logic [hdtb_pkg::COL_W-1:0]  bol_inc;

   assign n       = hdtb_pkg::hex_value(ch);
   assign is_lf   = (ch == hdtb_pkg::CH_LF);
   assign bol_inc = bol_ff + hdtb_pkg::COL_W'(1);
   assign addr    = cfg.base + ro_ff;
   assign data    = {last_ff.val, n.val};

   always_comb begin
      ig_in      = ig_ff;
      last_in    = last_ff;
      prior_in   = prior_ff;
      addr_ph_in = addr_ph_ff;
      bol_in     = bol_ff;
      skip_in    = skip_ff;
      ro_in      = ro_ff;
      emit       = 1'b0;

      if (skip_ff) begin
         if (is_lf) begin
            skip_in    = 1'b0;
            if (!cfg.ps) ro_in = '0;
            addr_ph_in = 1'b1;
            bol_in     = '0;
            ig_in      = 1'b1;
         end
      end else if (ch == hdtb_pkg::CH_CR) begin
      end else if (cfg.ps && (ch == hdtb_pkg::CH_SPACE || is_lf || ch == hdtb_pkg::CH_TAB)) begin
      end else begin
         // shift the digit history; older digit is prior_ff
         prior_in = last_ff;
         last_in  = n;
         if (!n.vld && ig_ff) begin
         end else begin
            ig_in = 1'b0;
            if (!cfg.ps && (addr_ph_ff || bol_ff >= cfg.cols)) begin
               // line offset collection; no end-of-line handling here
               if (!n.vld) begin
                  addr_ph_in = 1'b0;
                  bol_in     = '0;
               end else begin
                  ro_in = {ro_ff[hdtb_pkg::ADDR_W-5:0], n.val};
               end
            end else begin
               if (last_ff.vld && n.vld) begin
                  emit        = 1'b1;
                  ro_in       = ro_ff + hdtb_pkg::ADDR_W'(1);
                  last_in.vld = 1'b0;
                  if (!cfg.ps) begin
                     bol_in = bol_inc;
                     if (bol_inc >= cfg.cols) skip_in = 1'b1;
                  end
               end else if (!n.vld && !last_ff.vld && !prior_ff.vld) begin
                  if (!is_lf) skip_in = 1'b1;
               end
               if (!skip_in && is_lf) begin
                  if (!cfg.ps) ro_in = '0;
                  addr_ph_in = 1'b1;
                  bol_in     = '0;
                  ig_in      = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ig_ff      <= 1'b1;
         last_ff    <= '{vld: 1'b0, val: 4'd0};
         prior_ff   <= '{vld: 1'b1, val: 4'd0};
         addr_ph_ff <= 1'b1;
         bol_ff     <= '0;
         skip_ff    <= 1'b0;
         ro_ff      <= '0;
      end else if (fire) begin
         ig_ff      <= ig_in;
         last_ff    <= last_in;
         prior_ff   <= prior_in;
         addr_ph_ff <= addr_ph_in;
         bol_ff     <= bol_in;
         skip_ff    <= skip_in;
         ro_ff      <= ro_in;
      end
   end

   a_no_emit_in_skip: assert property (@(posedge clock) disable iff (reset)
      emit |-> !skip_ff)
      else $error("byte decoded while a line is being skipped");

   a_plain_emit_not_addr: assert property (@(posedge clock) disable iff (reset)
      (emit && !cfg.ps) |-> !addr_ph_ff)
      else $error("byte decoded during line offset collection");

   a_pair_consumed: assert property (@(posedge clock) disable iff (reset)
      (fire && emit) |=> !last_ff.vld)
      else $error("digit pair not consumed after decode");

   a_bol_range: assert property (@(posedge clock) disable iff (reset)
      bol_ff <= hdtb_pkg::COL_W'(hdtb_pkg::MAX_COLUMNS))
      else $error("byte count on line out of range");

endmodule

[hw/rtl/hex_dump_text_to_binary.sv]
// Hex dump text to binary parser: one text character in, at most one decoded
// byte with its 48-bit address out. Depends on hdtb_pkg, hdtb_csr, hdtb_parse.
//
// Takes one character per cycle; a character is held in the input register and
// a byte decoded from it shows as result valid from the result register. The
// parser state updates as the character moves from the input register to the
// result register, so a new character enters every cycle as long as the result
// side is not stalled. Carriage returns are dropped. In plain
// mode each line starts with a hex offset, then up to 'columns' digit pairs are
// decoded and the rest of the line is dropped; in postscript mode blanks, tabs
// and newlines are dropped and the offset just runs on. Byte address is
// base_offset plus the offset, modulo 2^48. Write the configuration only while
// no item is in flight.
module hex_dump_text_to_binary (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_text_char,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [hdtb_pkg::ADDR_W-1:0]       rsp_byte_address,
   output logic [7:0]                        rsp_data_byte,
   input  logic                              csr_wr_en,
   input  logic [hdtb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [hdtb_pkg::CSR_DATA_W-1:0]   csr_data
);

   hdtb_pkg::cfg_type           cfg;
   logic                        in_vld_ff, in_vld_in;
   logic [7:0]                  in_ch_ff;
   logic                        out_vld_ff, out_vld_in;
   logic [hdtb_pkg::ADDR_W-1:0] out_addr_ff;
   logic [7:0]                  out_data_ff;
   logic                        fire, req_take, emit;
   logic [hdtb_pkg::ADDR_W-1:0] addr;
   logic [7:0]                  data;

   hdtb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   hdtb_parse u_parse (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .ch    (in_ch_ff),
      .cfg   (cfg),
      .emit  (emit),
      .addr  (addr),
      .data  (data)
   );

   // the step runs when the result register is free or being drained
   assign fire      = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !fire;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_take)  in_vld_in = 1'b1;
      else if (fire) in_vld_in = 1'b0;
      out_vld_in = out_vld_ff;
      if (fire)            out_vld_in = emit;
      else if (!rsp_stall) out_vld_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) in_ch_ff <= req_text_char;
      if (fire && emit) begin
         out_addr_ff <= addr;
         out_data_ff <= data;
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_byte_address = out_addr_ff;
   assign rsp_data_byte    = out_data_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && rsp_stall) |-> !fire)
      else $error("stalled result overwritten");

   a_step_needs_item: assert property (@(posedge clock) disable iff (reset)
      fire |-> in_vld_ff)
      else $error("parser stepped without an item");

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      (fire && emit) |=> out_vld_ff)
      else $error("decoded byte lost");

endmodule
